// ===== rtl/usbep0_pkg.sv =====
// Shared types and constants for the USB endpoint 0 setup request decoder.
`timescale 1ns / 1ps
`default_nettype none
package usbep0_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_DATA_W  = 48;

  localparam logic [2:0] MAX_CONFIG_DESCS = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_DESC_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_DESC_SIZE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_DESC_COUNT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_DESC_SIZES = 2'd3;

  // bmRequestType fields
  localparam logic [1:0] TYPE_STD   = 2'd0;
  localparam logic [1:0] TYPE_CLASS = 2'd1;
  localparam logic [4:0] RCPT_DEV   = 5'd0;
  localparam logic [4:0] RCPT_IF    = 5'd1;
  localparam logic [4:0] RCPT_EP    = 5'd2;

  // Standard request codes
  localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] RQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

  // Descriptor types
  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;

  typedef enum logic [2:0] {
    ACT_STALL    = 3'd0,
    ACT_STATUS   = 3'd1,
    ACT_DESC     = 3'd2,
    ACT_HALT     = 3'd3,
    ACT_CLASS    = 3'd4,
    ACT_CLASS_IF = 3'd5
  } action_t;

  typedef struct packed {
    logic [15:0] request_length;
    logic [15:0] request_index;
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
  } setup_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic        configured;
    logic [6:0]  device_address;
    logic [15:0] halt_endpoint;
    logic [15:0] transfer_length;
    logic [1:0]  desc_index;
    logic        desc_kind;
    action_t     action;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/usb_ep0_setup_request_decoder.sv =====
// Top level: USB endpoint 0 setup request decoder with two-entry output stage.
`timescale 1ns / 1ps
`default_nettype none
// One setup request is accepted per clock while the skid entry is empty; its
// action is registered into the output register or the skid entry. Decode is
// a single pass of logic from the accepted request into the output register;
// the skid entry keeps s_tready registered, so a request is taken even in the
// cycle a finished result is still waiting. Sustained rate is one request per
// cycle while m_tready stays high. Address and configured flag change on the
// accepting edge and the result carries the new values. The user must write
// configuration registers via cfg_write/cfg_index/cfg_data only while no
// request is in flight; the block does not enforce this.
module usb_ep0_setup_request_decoder (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write,
  input  wire [usbep0_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [usbep0_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // request_type[7:0], request_code[15:8], request_value[31:16],
  // request_index[47:32], request_length[63:48]
  input  wire [usbep0_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // action[2:0], desc_kind[3], desc_index[5:4], transfer_length[21:6],
  // halt_endpoint[37:22], device_address[44:38], configured[45], zero[47:46]
  output logic [usbep0_pkg::OUT_DATA_W-1:0] m_tdata
);
  import usbep0_pkg::*;

  logic        device_desc_count;
  logic [7:0]  device_desc_size;
  logic [2:0]  config_desc_count;
  logic [63:0] config_desc_sizes;

  logic [6:0]  address_reg;
  logic [6:0]  address_reg_next;
  logic        configured_flag;
  logic        configured_flag_next;

  setup_t      req;
  result_t     res;
  result_t     out_q;
  result_t     skid_q;
  logic        out_valid;
  logic        skid_valid;
  logic        load;

  logic        is_std;
  logic        dir_in;
  logic [4:0]  rcpt;
  logic [7:0]  dtype;
  logic [7:0]  didx;
  logic [2:0]  cfg_count;
  logic        dev_ok;
  logic        cfg_ok;
  logic [15:0] desc_size;
  logic        halt_ok;
  logic        set_addr;
  logic        set_cfg;
  logic        if_class;

  assign req      = setup_t'(s_tdata);
  assign s_tready = !skid_valid;
  assign load     = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_desc_count <= 1'b1;
      device_desc_size  <= 8'd18;
      config_desc_count <= 3'd1;
      config_desc_sizes <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_DESC_COUNT: device_desc_count <= cfg_data[0];
        REG_DEVICE_DESC_SIZE:  device_desc_size  <= cfg_data[7:0];
        REG_CONFIG_DESC_COUNT: config_desc_count <= cfg_data[2:0];
        REG_CONFIG_DESC_SIZES: config_desc_sizes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode
  always_comb begin
    is_std = req.request_type[6:5] == TYPE_STD;
    dir_in = req.request_type[7];
    rcpt   = req.request_type[4:0];
    dtype  = req.request_value[15:8];
    didx   = req.request_value[7:0];

    cfg_count = (config_desc_count > MAX_CONFIG_DESCS) ? MAX_CONFIG_DESCS
                                                       : config_desc_count;
    dev_ok = (dtype == DT_DEVICE) && (didx < {7'd0, device_desc_count});
    cfg_ok = (dtype == DT_CONFIG) && (didx < {5'd0, cfg_count});

    case (didx[1:0])
      2'd0:    desc_size = config_desc_sizes[15:0];
      2'd1:    desc_size = config_desc_sizes[31:16];
      2'd2:    desc_size = config_desc_sizes[47:32];
      default: desc_size = config_desc_sizes[63:48];
    endcase
    if (dtype == DT_DEVICE) begin
      desc_size = {8'd0, device_desc_size};
    end

    // endpoint halt is the only feature that can be cleared
    halt_ok  = (req.request_code == RQ_CLEAR_FEATURE) && !dir_in && (rcpt == RCPT_EP) &&
               configured_flag && (req.request_value == 16'd0) &&
               (req.request_index[3:0] != 4'd0);
    set_addr = (rcpt == RCPT_DEV) && (req.request_code == RQ_SET_ADDRESS) && !dir_in;
    set_cfg  = (rcpt == RCPT_DEV) && (req.request_code == RQ_SET_CONFIGURATION) &&
               !dir_in && (req.request_value[7:0] == 8'd1);
    if_class = (rcpt == RCPT_IF) &&
               (req.request_code != RQ_CLEAR_FEATURE) &&
               (req.request_code != RQ_GET_STATUS) &&
               (req.request_code != RQ_SET_FEATURE) &&
               (req.request_code != RQ_GET_INTERFACE) &&
               (req.request_code != RQ_SET_INTERFACE);

    address_reg_next     = address_reg;
    configured_flag_next = configured_flag;
    res                  = '0;
    res.action           = ACT_STALL;

    if (is_std) begin
      if (halt_ok) begin
        res.action        = ACT_HALT;
        res.halt_endpoint = req.request_index;
      end else if (set_addr) begin
        res.action       = ACT_STATUS;
        address_reg_next = req.request_value[6:0];
      end else if (set_cfg) begin
        res.action           = ACT_STATUS;
        configured_flag_next = 1'b1;
      end else if (if_class) begin
        res.action = ACT_CLASS_IF;
      end else if ((rcpt == RCPT_DEV) && (req.request_code == RQ_GET_DESCRIPTOR) &&
                   dir_in && (dev_ok || cfg_ok)) begin
        res.action          = ACT_DESC;
        res.desc_kind       = cfg_ok;
        res.desc_index      = didx[1:0];
        res.transfer_length = (desc_size < req.request_length) ? desc_size
                                                               : req.request_length;
      end
    end else if (req.request_type[6:5] == TYPE_CLASS) begin
      res.action = ACT_CLASS;
    end

    res.device_address = address_reg_next;
    res.configured     = configured_flag_next;
  end

  // Device state
  always_ff @(posedge clk) begin
    if (rst) begin
      address_reg     <= '0;
      configured_flag <= 1'b0;
    end else if (load) begin
      address_reg     <= address_reg_next;
      configured_flag <= configured_flag_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (load) begin
        out_q <= res;
      end
    end else if (load) begin
      skid_q <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_configured_sticky: assert property (@(posedge clk) disable iff (rst)
    configured_flag |=> configured_flag)
    else $error("configured flag cleared without reset");

  a_halt_needs_config: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.action == ACT_HALT) |-> out_q.configured)
    else $error("halt cleared while not configured");

  a_desc_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.action != ACT_DESC) |->
      (out_q.transfer_length == 16'd0 && !out_q.desc_kind && out_q.desc_index == 2'd0))
    else $error("descriptor fields set on non-descriptor action");

  a_halt_field_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.action != ACT_HALT) |-> out_q.halt_endpoint == 16'd0)
    else $error("halt endpoint set on non-halt action");

endmodule
`default_nettype wire
